// ----- sv/bsm_pkg.sv -----
// Package for the bounded stack with running maximum.
// Holds sizes, command codes and the cell control struct; no dependencies.
package bsm_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 2;
  localparam int GRP    = 8;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic first;
  } cell_ctl_t;

endpackage

// ----- sv/bsm_cell.sv -----
// One stack cell: a stored word and the running maximum of it and all older words.
// Shifts with its neighbors on push and pop; depends on bsm_pkg.
module bsm_cell
  import bsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             is_head,
  input  logic [PTR_W-1:0] cell_pos,
  input  word_t            up_word,
  input  word_t            up_max,
  input  word_t            dn_word,
  input  word_t            dn_max,
  input  logic [FILL_W-1:0] fill,
  input  logic [PTR_W-1:0] idx,
  input  logic             idx_ok,
  output word_t            word,
  output word_t            run_max,
  output word_t            hit_word
);

  word_t word_r, word_nxt;
  word_t max_r, max_nxt;
  word_t head_max;
  logic [SUM_W-1:0] sum;
  logic hit;

  always_comb begin
    if (ctl.first || (up_word > max_r)) begin
      head_max = up_word;
    end else begin
      head_max = max_r;
    end
    word_nxt = word_r;
    max_nxt  = max_r;
    if (ctl.push) begin
      word_nxt = up_word;
      max_nxt  = is_head ? head_max : up_max;
    end else if (ctl.pop) begin
      word_nxt = dn_word;
      max_nxt  = dn_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
    max_r <= max_nxt;
  end

  // store position of this cell is (fill - 1 - cell_pos) mod DEPTH
  assign sum = SUM_W'(cell_pos) + SUM_W'(idx) + SUM_W'(1);
  assign hit = idx_ok && ((sum == SUM_W'(fill)) || (sum == SUM_W'(fill) + SUM_W'(DEPTH)));

  assign word     = word_r;
  assign run_max  = max_r;
  assign hit_word = hit ? word_r : '0;

endmodule

// ----- sv/bsm_gather.sv -----
// Two-level OR tree that collects the one selected cell word.
// First level is registered per group of cells; depends on bsm_pkg.
module bsm_gather
  import bsm_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t words [DEPTH],
  output word_t sel_word
);

  word_t grp_r [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    word_t acc [GRP+1];
    assign acc[0] = '0;
    for (genvar k = 0; k < GRP; k++) begin : g_term
      if (g * GRP + k < DEPTH) begin : g_on
        assign acc[k+1] = acc[k] | words[g*GRP+k];
      end else begin : g_off
        assign acc[k+1] = acc[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        grp_r[g] <= acc[GRP];
      end
    end
  end

  always_comb begin
    sel_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      sel_word = sel_word | grp_r[g];
    end
  end

endmodule

// ----- sv/bounded_stack_with_max.sv -----
// Top level of the bounded stack with running maximum: a ring of cells,
// an OR tree for the indexed read and the request sequencer. Depends on bsm_pkg.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid / in_tready | tdata: value, index; tuser: cmd
//  out_    | out | out_tvalid/out_tready | tdata: depth_used .. greatest
//
// The cell ring updates at the accepting edge; the indexed read then passes the
// registered group stage of the OR tree and the output register to the result.
// One request is in flight: the next is taken the cycle after the result leaves.
// A stalled result holds until taken.
// Synchronous reset clears the count and every stored word at once.
module bounded_stack_with_max
  import bsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [37:32] index, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [6:0] depth_used, [7] is_full, [8] is_empty,
                                  // [9] ignored, [41:10] word_at_index,
                                  // [73:42] greatest, [79:74] zero
);

  typedef enum logic [1:0] {ST_IDLE, ST_GATH, ST_SUM, ST_OUT} state_t;

  state_t state_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  idx_r;
  logic              idx_ok_r;
  logic              ign_r, ign_nxt;
  logic              out_valid_r;
  logic [79:0]       out_data_r;

  logic       accept;
  logic [CMD_W-1:0] cmd;
  word_t      value;
  logic [IDX_W-1:0] index;
  cell_ctl_t  ctl;
  logic       full, empty;

  word_t words [DEPTH];
  word_t maxes [DEPTH];
  word_t hits  [DEPTH];
  word_t sel_word;
  word_t greatest;

  assign cmd   = in_tuser;
  assign value = word_t'(in_tdata[31:0]);
  assign index = in_tdata[37:32];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (fill_r == FILL_W'(DEPTH));
  assign empty     = (fill_r == '0);

  always_comb begin
    ctl.push  = 1'b0;
    ctl.pop   = 1'b0;
    ctl.first = empty;
    ign_nxt   = 1'b0;
    fill_nxt  = fill_r;
    if (accept) begin
      case (cmd)
        CMD_PUSH: begin
          ign_nxt  = full;
          ctl.push = !full;
          if (!full) fill_nxt = fill_r + FILL_W'(1);
        end
        CMD_POP: begin
          ign_nxt = empty;
          ctl.pop = !empty;
          if (!empty) fill_nxt = fill_r - FILL_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    bsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .is_head  ((j == 0) ? 1'b1 : 1'b0),
      .cell_pos (PTR_W'(j)),
      .up_word  ((j == 0) ? value : words[(j + DEPTH - 1) % DEPTH]),
      .up_max   (maxes[(j + DEPTH - 1) % DEPTH]),
      .dn_word  (words[(j + 1) % DEPTH]),
      .dn_max   (maxes[(j + 1) % DEPTH]),
      .fill     (fill_r),
      .idx      (idx_r),
      .idx_ok   (idx_ok_r),
      .word     (words[j]),
      .run_max  (maxes[j]),
      .hit_word (hits[j])
    );
  end

  bsm_gather u_gather (
    .clk      (clk),
    .en       (state_r == ST_GATH),
    .words    (hits),
    .sel_word (sel_word)
  );

  assign greatest = empty ? word_t'(-1) : maxes[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) state_r <= ST_GATH;
        end
        ST_GATH: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= PTR_W'(index);
      idx_ok_r <= (int'(index) < DEPTH);
      ign_r    <= ign_nxt;
    end
    if (state_r == ST_SUM) begin
      out_data_r <= {6'd0, greatest, sel_word, ign_r, empty, full, 7'(fill_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/bsm_checker.sv -----
// Port-level checker for the bounded stack with running maximum, and its bind.
// Watches the result channel only; depends on bsm_pkg.
module bsm_checker
  import bsm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[7] && out_tdata[8]))
    else $error("full and empty together");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == (out_tdata[6:0] == 7'd0)))
    else $error("empty flag disagrees with count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == (out_tdata[6:0] == 7'(DEPTH))))
    else $error("full flag disagrees with count");

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[73:42] == 32'hFFFF_FFFF)
    else $error("empty stack reports a maximum");

endmodule

bind bounded_stack_with_max bsm_checker u_bsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
